>>> rtl/core/dcs_pkg.sv
// Shared types and constants of the disc coverage stamp block.
// Used by dcs_datapath, dcs_ctrl and disc_coverage_stamp; depends on nothing.
package dcs_pkg;

   // defaults for the top-level parameters
   localparam int unsigned DEF_MAX_COLUMNS = 256;
   localparam int unsigned DEF_MAX_ROWS    = 256;
   localparam int unsigned DEF_COUNT_BITS  = 16;

   // fixed field widths
   localparam int unsigned CMD_BITS       = 2;
   localparam int unsigned COORD_BITS     = 8;
   localparam int unsigned RADIUS_BITS    = 8;
   localparam int unsigned GRID_REG_BITS  = 9;
   localparam int unsigned CSR_INDEX_BITS = 8;
   localparam int unsigned RESULT_BITS    = 16;
   // span of a clipped coordinate: 0 .. 2*255
   localparam int unsigned SPAN_BITS      = 9;
   localparam int unsigned RR_BITS        = 2 * RADIUS_BITS;
   localparam int unsigned SQ_BITS        = 2 * SPAN_BITS;
   localparam int unsigned DIST_BITS      = SQ_BITS + 1;

   localparam int unsigned REQ_DATA_BITS  = 3 * COORD_BITS;
   localparam int unsigned RSP_DATA_BITS  = 2 * RESULT_BITS;

   // grid register reset value
   localparam logic [GRID_REG_BITS-1:0] GRID_RESET = GRID_REG_BITS'(256);

   // command codes (code 3 is unused and answered with zeros)
   localparam logic [CMD_BITS-1:0] CMD_ADD  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_SUB  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_HEIGHT = 8'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DRAIN,
      ST_READ,
      ST_RWAIT,
      ST_FINISH
   } dcs_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the request
      logic setup;       // compute clip bounds, start scan counters
      logic step;        // issue the current cell and advance
      logic read_cell;   // read the requested cell
      logic finish;      // load the result register
      logic clear_step;  // zero one memory word
   } dcs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_BITS-1:0] command;
      logic                empty;      // clipped square holds no cell
      logic                last_cell;  // current cell is the last of the square
      logic                busy;       // cell pipeline still holds work
      logic                clear_last; // clearing the last memory word
   } dcs_status_type;

endpackage

>>> rtl/core/dcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dcs_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/dcs_datapath.sv
// Datapath: request and grid registers, clip bounds, cell scan counters,
// distance pipeline, counter read-modify-write and result register.
// Depends on dcs_pkg and dcs_ram.
module dcs_datapath #(
   parameter int unsigned MAX_COLUMNS = dcs_pkg::DEF_MAX_COLUMNS,
   parameter int unsigned MAX_ROWS    = dcs_pkg::DEF_MAX_ROWS,
   parameter int unsigned COUNT_BITS  = dcs_pkg::DEF_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dcs_pkg::dcs_cmd_type                cmd,
   output dcs_pkg::dcs_status_type             status,
   // request payload
   input  logic [dcs_pkg::CMD_BITS-1:0]        req_command,
   input  logic [dcs_pkg::REQ_DATA_BITS-1:0]   req_data,
   // configuration writes
   input  logic                                csr_write,
   input  logic [dcs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dcs_pkg::GRID_REG_BITS-1:0]   csr_data,
   // result payload
   output logic [dcs_pkg::RSP_DATA_BITS-1:0]   rsp_data
);

   localparam int unsigned DEPTH      = MAX_COLUMNS * MAX_ROWS;
   localparam int unsigned ADDR_BITS  = $clog2(DEPTH);
   localparam int unsigned GRID_MAX   = (1 << dcs_pkg::GRID_REG_BITS) - 1;
   localparam int unsigned COL_LIMIT  = (MAX_COLUMNS > GRID_MAX) ? GRID_MAX : MAX_COLUMNS;
   localparam int unsigned ROW_LIMIT  = (MAX_ROWS > GRID_MAX) ? GRID_MAX : MAX_ROWS;
   localparam int unsigned SB         = dcs_pkg::SPAN_BITS;
   localparam int unsigned RB         = dcs_pkg::RESULT_BITS;

   // request registers
   logic [dcs_pkg::CMD_BITS-1:0]    cmd_ff;
   logic [dcs_pkg::COORD_BITS-1:0]  cx_ff, cy_ff;
   logic [dcs_pkg::RADIUS_BITS-1:0] r_ff;

   // grid size registers
   logic [dcs_pkg::GRID_REG_BITS-1:0] grid_w_ff, grid_w_in;
   logic [dcs_pkg::GRID_REG_BITS-1:0] grid_h_ff, grid_h_in;

   // clip bounds and scan counters
   logic [SB-1:0] sx_ff, ex_ff, ey_ff;
   logic [SB-1:0] x_ff, x_in, y_ff, y_in;
   logic [dcs_pkg::RR_BITS-1:0] rr_ff;

   // cell pipeline
   logic                      v1_ff;
   logic [dcs_pkg::SQ_BITS-1:0] dx2_ff, dy2_ff;
   logic [ADDR_BITS-1:0]      addr1_ff;
   logic                      hit2_ff;
   logic [ADDR_BITS-1:0]      addr2_ff;

   // clearing pass, touched count, result
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic [RB-1:0]        touched_ff, touched_in;
   logic [RB-1:0]        rsp_count_ff, rsp_touched_ff;

   logic [SB-1:0] cx9, cy9, r9, used_w, used_h;
   logic [SB-1:0] lo_x, lo_y, hi_x, hi_y, raw_hx, raw_hy;
   logic          empty;
   logic [SB-1:0] dxa, dya;
   logic [dcs_pkg::DIST_BITS-1:0] dist_sq;
   logic          read_ok;
   logic [ADDR_BITS-1:0] cell_addr, cur_addr;
   logic                 ram_we, ram_re;
   logic [ADDR_BITS-1:0] ram_wa, ram_ra;
   logic [COUNT_BITS-1:0] ram_wd, ram_rd;
   logic [COUNT_BITS+RB-1:0] rd_wide;

   assign cx9 = SB'(cx_ff);
   assign cy9 = SB'(cy_ff);
   assign r9  = SB'(r_ff);

   // columns and rows in use, limited by the storage
   assign used_w = (32'(grid_w_ff) > COL_LIMIT) ? SB'(COL_LIMIT) : grid_w_ff;
   assign used_h = (32'(grid_h_ff) > ROW_LIMIT) ? SB'(ROW_LIMIT) : grid_h_ff;

   // clip the bounding square to the grid
   assign lo_x   = (cx9 < r9) ? '0 : cx9 - r9;
   assign lo_y   = (cy9 < r9) ? '0 : cy9 - r9;
   assign raw_hx = cx9 + r9;
   assign raw_hy = cy9 + r9;
   assign hi_x   = (raw_hx > used_w - SB'(1)) ? used_w - SB'(1) : raw_hx;
   assign hi_y   = (raw_hy > used_h - SB'(1)) ? used_h - SB'(1) : raw_hy;
   assign empty  = (used_w == '0) || (used_h == '0) || (lo_x > hi_x) || (lo_y > hi_y);

   // request and grid registers
   always_comb begin
      grid_w_in = grid_w_ff;
      grid_h_in = grid_h_ff;
      if (csr_write && csr_index == dcs_pkg::REG_GRID_WIDTH) begin
         grid_w_in = csr_data;
      end
      if (csr_write && csr_index == dcs_pkg::REG_GRID_HEIGHT) begin
         grid_h_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= dcs_pkg::GRID_RESET;
         grid_h_ff <= dcs_pkg::GRID_RESET;
      end else begin
         grid_w_ff <= grid_w_in;
         grid_h_ff <= grid_h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         cx_ff  <= req_data[dcs_pkg::COORD_BITS-1:0];
         cy_ff  <= req_data[2*dcs_pkg::COORD_BITS-1:dcs_pkg::COORD_BITS];
         r_ff   <= req_data[dcs_pkg::REQ_DATA_BITS-1:2*dcs_pkg::COORD_BITS];
      end
      if (cmd.setup) begin
         sx_ff <= lo_x;
         ex_ff <= hi_x;
         ey_ff <= hi_y;
         rr_ff <= dcs_pkg::RR_BITS'(r_ff) * dcs_pkg::RR_BITS'(r_ff);
      end
   end

   // scan counters: row by row over the clipped square
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (cmd.setup) begin
         x_in = lo_x;
         y_in = lo_y;
      end else if (cmd.step) begin
         if (x_ff == ex_ff) begin
            x_in = sx_ff;
            y_in = y_ff + SB'(1);
         end else begin
            x_in = x_ff + SB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   // stage 1: squared offsets and address of the current cell
   assign dxa = (cx9 >= x_ff) ? cx9 - x_ff : x_ff - cx9;
   assign dya = (cy9 >= y_ff) ? cy9 - y_ff : y_ff - cy9;
   assign cur_addr  = ADDR_BITS'(32'(y_ff) * MAX_COLUMNS + 32'(x_ff));
   assign cell_addr = ADDR_BITS'(32'(cy_ff) * MAX_COLUMNS + 32'(cx_ff));

   // stage 2: inside test, counter read lands with it
   assign dist_sq = dcs_pkg::DIST_BITS'(dx2_ff) + dcs_pkg::DIST_BITS'(dy2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         hit2_ff <= 1'b0;
      end else begin
         v1_ff   <= cmd.step;
         hit2_ff <= v1_ff && (dist_sq <= dcs_pkg::DIST_BITS'(rr_ff));
      end
   end

   always_ff @(posedge clock) begin
      dx2_ff   <= dcs_pkg::SQ_BITS'(dxa) * dcs_pkg::SQ_BITS'(dxa);
      dy2_ff   <= dcs_pkg::SQ_BITS'(dya) * dcs_pkg::SQ_BITS'(dya);
      addr1_ff <= cur_addr;
      addr2_ff <= addr1_ff;
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
      end
   end

   // counter memory ports
   assign ram_re = v1_ff || cmd.read_cell;
   assign ram_ra = cmd.read_cell ? cell_addr : addr1_ff;
   assign ram_we = cmd.clear_step || hit2_ff;
   assign ram_wa = cmd.clear_step ? clr_addr_ff : addr2_ff;
   always_comb begin
      if (cmd.clear_step) begin
         ram_wd = '0;
      end else if (cmd_ff == dcs_pkg::CMD_SUB) begin
         ram_wd = ram_rd - COUNT_BITS'(1);
      end else begin
         ram_wd = ram_rd + COUNT_BITS'(1);
      end
   end

   dcs_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // touched cells, saturating
   always_comb begin
      touched_in = touched_ff;
      if (cmd.load) begin
         touched_in = '0;
      end else if (hit2_ff && touched_ff != '1) begin
         touched_in = touched_ff + RB'(1);
      end
   end

   always_ff @(posedge clock) begin
      touched_ff <= touched_in;
   end

   // result register
   assign read_ok = (cx9 < used_w) && (cy9 < used_h);
   assign rd_wide = {{RB{1'b0}}, ram_rd};

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_count_ff   <= (cmd_ff == dcs_pkg::CMD_READ && read_ok) ? rd_wide[RB-1:0] : '0;
         rsp_touched_ff <= touched_ff;
      end
   end

   assign rsp_data = {rsp_touched_ff, rsp_count_ff};

   // status to the controller
   assign status.command    = cmd_ff;
   assign status.empty      = empty;
   assign status.last_cell  = (x_ff == ex_ff) && (y_ff == ey_ff);
   assign status.busy       = v1_ff || hit2_ff;
   assign status.clear_last = (clr_addr_ff == ADDR_BITS'(DEPTH - 1));

endmodule

>>> rtl/core/dcs_ctrl.sv
// Controller: state machine that sequences clearing, stamps and reads,
// and owns the request ready and result valid. Depends on dcs_pkg.
module dcs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  dcs_pkg::dcs_status_type status,
   output dcs_pkg::dcs_cmd_type    cmd
);

   dcs_pkg::dcs_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dcs_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = dcs_pkg::ST_IDLE;
            end
         end
         dcs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = dcs_pkg::ST_DECODE;
            end
         end
         dcs_pkg::ST_DECODE: begin
            unique case (status.command)
               dcs_pkg::CMD_ADD,
               dcs_pkg::CMD_SUB:  state_in = status.empty ? dcs_pkg::ST_FINISH
                                                          : dcs_pkg::ST_SCAN;
               dcs_pkg::CMD_READ: state_in = dcs_pkg::ST_READ;
               default:           state_in = dcs_pkg::ST_FINISH;
            endcase
         end
         dcs_pkg::ST_SCAN: begin
            if (status.last_cell) begin
               state_in = dcs_pkg::ST_DRAIN;
            end
         end
         dcs_pkg::ST_DRAIN: begin
            if (!status.busy) begin
               state_in = dcs_pkg::ST_FINISH;
            end
         end
         dcs_pkg::ST_READ:  state_in = dcs_pkg::ST_RWAIT;
         dcs_pkg::ST_RWAIT: state_in = dcs_pkg::ST_FINISH;
         dcs_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = dcs_pkg::ST_IDLE;
            end
         end
         default: state_in = dcs_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         dcs_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
         dcs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         dcs_pkg::ST_DECODE: cmd.setup     = 1'b1;
         dcs_pkg::ST_SCAN:   cmd.step      = 1'b1;
         dcs_pkg::ST_READ:   cmd.read_cell = 1'b1;
         dcs_pkg::ST_FINISH: cmd.finish    = out_free;
         default:            cmd           = '0;
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcs_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/core/disc_coverage_stamp.sv
// Top level of the disc coverage stamp: grid of coverage counters with
// stamp, remove and read requests. Depends on dcs_pkg, dcs_ctrl, dcs_datapath.
//
//  channel  direction  handshake               payload
//  req_     in         req_tvalid/req_tready   tuser command, tdata center/radius
//  rsp_     out        rsp_tvalid/rsp_tready   tdata cell_count, cells_touched
//  csr_     in         csr_valid/csr_ready     csr_index, csr_data
//
// A stamp scans its clipped square one cell per cycle through the counter
// read-modify-write on the single memory write port. After reset a clearing
// pass zeroes all MAX_COLUMNS*MAX_ROWS memory words with req_tready low; csr
// writes are always taken. A finished result waits in the output register and
// the next request is accepted meanwhile; its own result waits for that slot.
module disc_coverage_stamp #(
   parameter int unsigned MAX_COLUMNS = dcs_pkg::DEF_MAX_COLUMNS,
   parameter int unsigned MAX_ROWS    = dcs_pkg::DEF_MAX_ROWS,
   parameter int unsigned COUNT_BITS  = dcs_pkg::DEF_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // requests
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dcs_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // center_x, center_y, radius
   input  logic [dcs_pkg::CMD_BITS-1:0]       req_tuser,  // command
   // results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dcs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // cell_count, cells_touched
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dcs_pkg::GRID_REG_BITS-1:0]  csr_data
);

   dcs_pkg::dcs_cmd_type    cmd;
   dcs_pkg::dcs_status_type status;

   assign csr_ready = 1'b1;

   dcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dcs_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_command (req_tuser),
      .req_data    (req_tdata),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_data    (rsp_tdata)
   );

endmodule

>>> tb/dcs_checker.sv
// Checker for the disc coverage stamp: watches the request, result and csr
// channels, keeps its own copy of the counter grid and compares every result.
// Depends on dcs_pkg.
module dcs_checker
   import dcs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // center_x, center_y, radius
   input  logic [CMD_BITS-1:0]       req_tuser,   // command
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // cell_count, cells_touched
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [GRID_REG_BITS-1:0]  csr_data,
   output int                        results_waiting,
   output int                        fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_COLS = DEF_MAX_COLUMNS;
   localparam int GRID_ROWS = DEF_MAX_ROWS;

   // same layout as rsp_tdata: cell_count in the low half
   typedef struct packed {
      logic [RESULT_BITS-1:0] cells_touched;
      logic [RESULT_BITS-1:0] cell_count;
   } disc_result_type;

   logic [DEF_COUNT_BITS-1:0] coverage_map [GRID_COLS*GRID_ROWS];
   logic [GRID_REG_BITS-1:0]  width_reg;
   logic [GRID_REG_BITS-1:0]  height_reg;
   disc_result_type           expected_q [$];
   disc_result_type           want_result;
   disc_result_type           got_result;

   function automatic int cols_in_use();
      return (int'(width_reg) > GRID_COLS) ? GRID_COLS : int'(width_reg);
   endfunction

   function automatic int rows_in_use();
      return (int'(height_reg) > GRID_ROWS) ? GRID_ROWS : int'(height_reg);
   endfunction

   // walk the clipped square, bump every cell inside the disc
   function automatic logic [RESULT_BITS-1:0] stamp_disc(int cx, int cy, int r, bit remove);
      int x_lo, x_hi, y_lo, y_hi, room, addr, x, y;
      int unsigned hits;
      hits = 0;
      x_lo = (cx - r < 0) ? 0 : cx - r;
      x_hi = (cx + r > cols_in_use() - 1) ? cols_in_use() - 1 : cx + r;
      y_lo = (cy - r < 0) ? 0 : cy - r;
      y_hi = (cy + r > rows_in_use() - 1) ? rows_in_use() - 1 : cy + r;
      for (y = y_lo; y <= y_hi; y++) begin
         room = r * r - (cy - y) * (cy - y);
         for (x = x_lo; x <= x_hi; x++) begin
            if ((cx - x) * (cx - x) <= room) begin
               addr = y * GRID_COLS + x;
               if (remove) begin
                  coverage_map[addr] = coverage_map[addr] - 1'b1;
               end else begin
                  coverage_map[addr] = coverage_map[addr] + 1'b1;
               end
               if (hits < 65535) hits++;
            end
         end
      end
      return RESULT_BITS'(hits);
   endfunction

   function automatic disc_result_type predict_result(logic [CMD_BITS-1:0] cmd,
                                                      logic [REQ_DATA_BITS-1:0] data);
      disc_result_type res;
      int cx, cy, r;
      res = '0;
      cx  = int'(data[COORD_BITS-1:0]);
      cy  = int'(data[2*COORD_BITS-1:COORD_BITS]);
      r   = int'(data[REQ_DATA_BITS-1:2*COORD_BITS]);
      case (cmd)
         CMD_ADD: begin
            res.cells_touched = stamp_disc(cx, cy, r, 1'b0);
         end
         CMD_SUB: begin
            res.cells_touched = stamp_disc(cx, cy, r, 1'b1);
         end
         CMD_READ: begin
            if (cx < cols_in_use() && cy < rows_in_use())
               res.cell_count = RESULT_BITS'(coverage_map[cy * GRID_COLS + cx]);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (coverage_map[i]) coverage_map[i] = '0;
         width_reg  = GRID_RESET;
         height_reg = GRID_RESET;
         expected_q.delete();
         fail_count = 0;
         results_waiting <= 0;
      end else begin
         // results first: one accepted this edge belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            got_result = rsp_tdata;
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result: cell_count %0d cells_touched %0d",
                        $time, got_result.cell_count, got_result.cells_touched);
               fail_count++;
            end else begin
               want_result = expected_q.pop_front();
               if (got_result.cell_count !== want_result.cell_count) begin
                  $display("%0t cell_count mismatch: expected %0d, actual %0d",
                           $time, want_result.cell_count, got_result.cell_count);
                  fail_count++;
               end
               if (got_result.cells_touched !== want_result.cells_touched) begin
                  $display("%0t cells_touched mismatch: expected %0d, actual %0d",
                           $time, want_result.cells_touched, got_result.cells_touched);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_GRID_WIDTH) begin
               width_reg = csr_data;
            end else if (csr_index == REG_GRID_HEIGHT) begin
               height_reg = csr_data;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_q = {expected_q, predict_result(req_tuser, req_tdata)};
         end
         results_waiting <= expected_q.size();
      end
   end

endmodule

>>> tb/tb.sv
// Top of the disc coverage stamp testbench: clock, reset, request and csr
// stimulus, result back-pressure and the verdict. Depends on dcs_pkg,
// dcs_checker and the disc_coverage_stamp RTL.
module tb;
   import dcs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_PCT       = 29;
   localparam int SCAN_BUDGET    = 3000;     // cap on clipped square cells per random stamp
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 34;
   localparam int CALM_PHASE     = PHASES - 1;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 300000;  // longer than a clearing pass and a full-grid stamp together

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;   // center_x, center_y, radius
   logic [CMD_BITS-1:0]       req_tuser = '0;   // command
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;        // cell_count, cells_touched
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [GRID_REG_BITS-1:0]  csr_data = '0;

   int results_waiting;
   int fail_count;
   int stuck_cycles = 0;
   bit calm = 1'b0;
   int cols_used = 256;
   int rows_used = 256;
   int last_cx = 0;
   int last_cy = 0;
   int last_r = 0;

   disc_coverage_stamp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   dcs_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .results_waiting (results_waiting),
      .fail_count      (fail_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result back-pressure
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // watchdog: cycles without any accepted transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   // one request, with random gaps ahead of it; tvalid stays high on return
   task automatic send_request(logic [CMD_BITS-1:0] cmd, int cx, int cy, int r);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {RADIUS_BITS'(r), COORD_BITS'(cy), COORD_BITS'(cx)};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop tvalid and wait for every result to come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both grid registers, sometimes followed by a write to an unused index
   task automatic configure_grid(int w, int h);
      logic [CSR_INDEX_BITS-1:0] idx [3];
      int val [3];
      int n, i;
      idx[0] = REG_GRID_WIDTH;
      val[0] = w;
      idx[1] = REG_GRID_HEIGHT;
      val[1] = h;
      idx[2] = CSR_INDEX_BITS'($urandom_range(255, 2));
      val[2] = int'($urandom);
      n = $urandom_range(1) ? 3 : 2;
      for (i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= GRID_REG_BITS'(val[i]);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cols_used = (w > 256) ? 256 : w;
      rows_used = (h > 256) ? 256 : h;
   endtask

   task automatic send_random_item();
      int pick, cx, cy, r, x_lim, y_lim, span_x, span_y;
      logic [CMD_BITS-1:0] cmd;
      pick = $urandom_range(99);
      if (pick < 45) cmd = CMD_ADD;
      else if (pick < 65) cmd = CMD_SUB;
      else if (pick < 95) cmd = CMD_READ;
      else cmd = CMD_UNUSED;
      x_lim = (cols_used > 0) ? cols_used - 1 : 0;
      y_lim = (rows_used > 0) ? rows_used - 1 : 0;
      if ($urandom_range(9) < 8) begin
         cx = $urandom_range(x_lim);
         cy = $urandom_range(y_lim);
      end else begin
         cx = $urandom_range(255);
         cy = $urandom_range(255);
      end
      // reads often land in the bounding square of the last disc so counts are nonzero
      if (cmd == CMD_READ && $urandom_range(1)) begin
         cx = last_cx + int'($urandom_range(2 * last_r)) - last_r;
         cy = last_cy + int'($urandom_range(2 * last_r)) - last_r;
         cx = (cx < 0) ? 0 : (cx > 255) ? 255 : cx;
         cy = (cy < 0) ? 0 : (cy > 255) ? 255 : cy;
      end
      pick = $urandom_range(99);
      if (pick < 60) r = $urandom_range(7);
      else if (pick < 88) r = $urandom_range(31);
      else r = $urandom_range(255);
      if (cmd == CMD_ADD || cmd == CMD_SUB) begin
         // halve the radius until the clipped square is cheap to scan
         forever begin
            span_x = ((cx + r > cols_used - 1) ? cols_used - 1 : cx + r) -
                     ((cx - r < 0) ? 0 : cx - r) + 1;
            span_y = ((cy + r > rows_used - 1) ? rows_used - 1 : cy + r) -
                     ((cy - r < 0) ? 0 : cy - r) + 1;
            if (span_x <= 0 || span_y <= 0 || span_x * span_y <= SCAN_BUDGET) break;
            r = r / 2;
         end
         last_cx = cx;
         last_cy = cy;
         last_r  = r;
      end
      send_request(cmd, cx, cy, r);
   endtask

   initial begin
      int phase_w [PHASES];
      int phase_h [PHASES];
      int p;
      phase_w = '{256, 1, 256, 0, 511, 0, 0, 256};
      phase_h = '{256, 256, 1, 9, 300, 0, 0, 256};
      phase_w[5] = $urandom_range(40, 1);
      phase_h[5] = $urandom_range(40, 1);
      phase_w[6] = $urandom_range(300, 2);
      phase_h[6] = $urandom_range(12, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // full grid after reset: extremes, clipping at corners, wrap, saturation
      send_request(CMD_READ, 0, 0, 0);
      send_request(CMD_READ, 255, 255, 255);
      send_request(CMD_ADD, 10, 10, 0);
      send_request(CMD_READ, 10, 10, 0);
      send_request(CMD_ADD, 0, 0, 3);
      send_request(CMD_ADD, 255, 255, 5);
      send_request(CMD_READ, 255, 255, 0);
      send_request(CMD_SUB, 255, 255, 5);
      send_request(CMD_SUB, 20, 20, 1);          // counters wrap below zero
      send_request(CMD_READ, 20, 20, 128);
      send_request(CMD_ADD, 20, 20, 1);
      send_request(CMD_UNUSED, 128, 64, 17);
      send_request(CMD_ADD, 128, 128, 255);      // whole grid, count saturates
      send_request(CMD_READ, 0, 0, 0);
      send_request(CMD_SUB, 128, 128, 255);
      wait_idle();

      // zero width, oversized height: nothing in use
      configure_grid(0, 511);
      send_request(CMD_ADD, 5, 5, 4);
      send_request(CMD_READ, 5, 5, 0);
      wait_idle();

      // single cell grid, some centres outside it
      configure_grid(1, 1);
      send_request(CMD_ADD, 0, 0, 200);
      send_request(CMD_ADD, 100, 100, 255);
      send_request(CMD_READ, 0, 0, 0);
      send_request(CMD_READ, 1, 0, 0);
      send_request(CMD_ADD, 200, 0, 0);
      wait_idle();

      // random phases over several grid settings; the last runs without gaps
      for (p = 0; p < PHASES; p++) begin
         configure_grid(phase_w[p], phase_h[p]);
         calm = (p == CALM_PHASE);
         repeat (PHASE_ITEMS) send_random_item();
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
